### rtl/button_edge_accumulator_remap_top_defines.svh
// assertion macros for the button edge accumulator checker
`ifndef BUTTON_EDGE_ACCUMULATOR_REMAP_TOP_DEFINES_SVH
`define BUTTON_EDGE_ACCUMULATOR_REMAP_TOP_DEFINES_SVH

// same-cycle implication, clocked by clk, off while rst is high
`define BEA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bea same-cycle check failed");

// next-cycle implication, clocked by clk, off while rst is high
`define BEA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bea next-cycle check failed");

`endif

### rtl/bea_pkg.sv
// types and constants shared by the button edge accumulator modules
package bea_pkg;

  localparam int BTN_W = 16;
  localparam int IDX_W = 4;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_ADD    = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BTN_W-1:0]   raw_buttons;
    logic               repeat_tick;
    logic [IDX_W-1:0]   target_button;
    logic [IDX_W-1:0]   source_button;
  } in_item_t;

  typedef struct packed {
    logic [BTN_W-1:0] mapped_hold;
    logic [BTN_W-1:0] mapped_trigger;
    logic [BTN_W-1:0] mapped_release;
    logic [BTN_W-1:0] mapped_repeat;
    logic [BTN_W-1:0] plain_hold;
    logic [BTN_W-1:0] plain_trigger;
    logic [BTN_W-1:0] plain_release;
    logic [BTN_W-1:0] plain_repeat;
  } out_item_t;

  typedef struct packed {
    logic sample;
    logic clear;
  } accum_ctl_t;

  typedef struct packed {
    logic             en;
    logic             set;
    logic [IDX_W-1:0] tgt;
    logic [IDX_W-1:0] src;
  } edit_t;

endpackage

### rtl/bea_remap.sv
// remap matrix: row edits and the mapping of current and previous raw samples
module bea_remap #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  bea_pkg::edit_t edit,
  input  logic [W-1:0]   raw_now,
  input  logic [W-1:0]   raw_prev,
  output logic [W-1:0]   mapped_now,
  output logic [W-1:0]   mapped_prev
);
  import bea_pkg::*;

  logic [W-1:0] rows [W];
  logic [W-1:0] rows_next [W];

  // a row or bit index outside the matrix never matches, so such edits drop out
  always_comb begin
    for (int i = 0; i < W; i++) begin
      for (int j = 0; j < W; j++) begin
        if (edit.en && edit.tgt == IDX_W'(i) && edit.src == IDX_W'(j)) begin
          rows_next[i][j] = edit.set;
        end else begin
          rows_next[i][j] = rows[i][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < W; i++) begin
        for (int j = 0; j < W; j++) begin
          rows[i][j] <= (i == j);
        end
      end
    end else begin
      rows <= rows_next;
    end
  end

  always_comb begin
    for (int i = 0; i < W; i++) begin
      mapped_now[i]  = |(raw_now & rows[i]);
      mapped_prev[i] = |(raw_prev & rows[i]);
    end
  end

endmodule

### rtl/bea_accum.sv
// one set of hold, trigger, release and repeat accumulators
module bea_accum #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  bea_pkg::accum_ctl_t ctl,
  input  logic [W-1:0]        now,
  input  logic [W-1:0]        prev,
  input  logic                tick,
  output logic [W-1:0]        hold,
  output logic [W-1:0]        trig,
  output logic [W-1:0]        rel,
  output logic [W-1:0]        rpt
);
  import bea_pkg::*;

  logic [W-1:0] edge_on, edge_off, rep_now, plain_off, cancel_off, other;
  logic [W-1:0] hold_next, trig_next, rel_next, rpt_next;

  always_comb begin
    edge_on    = ~prev & now;
    edge_off   = prev & ~now;
    rep_now    = tick ? now : '0;
    // release after an accumulated trigger cancels the press entirely
    plain_off  = edge_off & ~trig;
    // re-press after an accumulated release cancels the release
    cancel_off = ~edge_off & rel & edge_on;
    other      = ~edge_off & ~cancel_off;
    hold_next  = ((hold | now) & other) | cancel_off;
    trig_next  = (trig | edge_on) & other;
    rel_next   = (rel & other) | plain_off;
    rpt_next   = ((rpt | rep_now) & other) | (rep_now & cancel_off);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hold <= '0;
      trig <= '0;
      rel  <= '0;
      rpt  <= '0;
    end else if (ctl.sample) begin
      hold <= hold_next;
      trig <= trig_next;
      rel  <= rel_next;
      rpt  <= rpt_next;
    end
  end

endmodule

### rtl/button_edge_accumulator_remap_top.sv
// button edge accumulator with remap matrix, top level
//
// Input channel (in_valid / in_stall / in_data) takes one transaction per
// cycle while in_stall is low: a button sample, a frame end, or an
// add/remove edit of one remap matrix row. Samples update the plain and the
// remapped hold, trigger, release and repeat accumulators; edits change the
// matrix for later items. Only a frame end produces an output transaction
// (out_valid / out_stall / out_data) carrying the accumulated flags, after
// which they are cleared. A frame end is registered in the input register,
// then its flags are captured in the output register. Throughput is one
// item per cycle while in_stall is low, set by the input register and the
// single output register.
// When the receiver stalls, the output holds; samples and edits keep flowing,
// and only a frame end waiting behind a full stalled output raises in_stall.
// Reset clears the accumulators and the previous sample, sets the matrix to
// identity and drops both valids; it is synchronous to clk.
module button_edge_accumulator_remap_top #(
  parameter int NUM_BUTTONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bea_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bea_pkg::out_item_t out_data
);
  import bea_pkg::*;

  localparam int NB = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;

  logic         s1_valid;
  in_item_t     s1_item;
  logic         s1_go;
  logic [NB-1:0] previous_raw;
  logic [NB-1:0] raw_now;
  accum_ctl_t   ctl;
  edit_t        edit;
  logic [NB-1:0] mapped_now, mapped_prev;
  logic [NB-1:0] m_hold, m_trig, m_rel, m_rpt;
  logic [NB-1:0] p_hold, p_trig, p_rel, p_rpt;

  // only a frame end needs the output register free
  assign s1_go    = s1_valid && !(s1_item.kind == KIND_FRAME && out_valid && out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign raw_now  = s1_item.raw_buttons[NB-1:0];

  always_comb begin
    ctl.sample = s1_go && s1_item.kind == KIND_SAMPLE;
    ctl.clear  = s1_go && s1_item.kind == KIND_FRAME;
    edit.en    = s1_go && (s1_item.kind == KIND_ADD || s1_item.kind == KIND_REMOVE);
    edit.set   = s1_item.kind == KIND_ADD;
    edit.tgt   = s1_item.target_button;
    edit.src   = s1_item.source_button;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw <= '0;
    end else if (ctl.sample) begin
      previous_raw <= raw_now;
    end
  end

  bea_remap #(.W(NB)) u_remap (
    .clk         (clk),
    .rst         (rst),
    .edit        (edit),
    .raw_now     (raw_now),
    .raw_prev    (previous_raw),
    .mapped_now  (mapped_now),
    .mapped_prev (mapped_prev)
  );

  bea_accum #(.W(NB)) u_acc_mapped (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .now  (mapped_now),
    .prev (mapped_prev),
    .tick (s1_item.repeat_tick),
    .hold (m_hold),
    .trig (m_trig),
    .rel  (m_rel),
    .rpt  (m_rpt)
  );

  bea_accum #(.W(NB)) u_acc_plain (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .now  (raw_now),
    .prev (previous_raw),
    .tick (s1_item.repeat_tick),
    .hold (p_hold),
    .trig (p_trig),
    .rel  (p_rel),
    .rpt  (p_rpt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.clear) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      out_data.mapped_hold    <= BTN_W'(m_hold);
      out_data.mapped_trigger <= BTN_W'(m_trig);
      out_data.mapped_release <= BTN_W'(m_rel);
      out_data.mapped_repeat  <= BTN_W'(m_trig | m_rpt);
      out_data.plain_hold     <= BTN_W'(p_hold);
      out_data.plain_trigger  <= BTN_W'(p_trig);
      out_data.plain_release  <= BTN_W'(p_rel);
      out_data.plain_repeat   <= BTN_W'(p_trig | p_rpt);
    end
  end

endmodule

### rtl/bea_checker.sv
// port-level checker for the button edge accumulator, bound to the top level
module bea_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input bea_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input bea_pkg::out_item_t out_data
);
  import bea_pkg::*;

`include "button_edge_accumulator_remap_top_defines.svh"

  logic frame_acc;
  logic flags_ok;

  assign frame_acc = in_valid && !in_stall && in_data.kind == KIND_FRAME;

  // trigger and release never both set, repeat always covers trigger
  assign flags_ok = ((out_data.mapped_trigger & out_data.mapped_release) == '0) &&
                    ((out_data.plain_trigger & out_data.plain_release) == '0) &&
                    ((out_data.mapped_trigger & ~out_data.mapped_repeat) == '0) &&
                    ((out_data.plain_trigger & ~out_data.plain_repeat) == '0);

  // a stalled result stays put
  `BEA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // a new result follows an accepted frame end, through the input and output registers
  `BEA_ASSERT_IMP(a_out_src, $rose(out_valid), $past(frame_acc, 2))

  // input backpressure only comes from a full, stalled output
  `BEA_ASSERT_IMP(a_in_stall, in_stall, out_valid && out_stall)

  `BEA_ASSERT_IMP(a_flags, out_valid, flags_ok)

endmodule

bind button_edge_accumulator_remap_top bea_checker u_bea_checker (.*);

### sim/button_edge_accumulator_remap_top_tb.sv
// self-checking testbench for the button edge accumulator with remap matrix
module button_edge_accumulator_remap_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bea_pkg::*;

  typedef struct packed {
    logic [BTN_W-1:0] hold;
    logic [BTN_W-1:0] trig;
    logic [BTN_W-1:0] rel;
    logic [BTN_W-1:0] rpt;
  } flag_acc_t;

  class frame_flag_board;
    logic [BTN_W-1:0] last_raw;
    logic [BTN_W-1:0] remap_rows [BTN_W];
    flag_acc_t        mapped_acc;
    flag_acc_t        plain_acc;
    out_item_t        frames_due [$];
    int               errors;
    int               items_seen;
    int               samples_seen;
    int               edits_seen;
    int               frames_checked;

    function new();
      last_raw = '0;
      for (int i = 0; i < BTN_W; i++) begin
        remap_rows[i] = '0;
        remap_rows[i][i] = 1'b1;
      end
      mapped_acc = '0;
      plain_acc = '0;
      errors = 0;
      items_seen = 0;
      samples_seen = 0;
      edits_seen = 0;
      frames_checked = 0;
    endfunction

    // logical button i is down when any raw button of row i is down
    function logic [BTN_W-1:0] remap(logic [BTN_W-1:0] raw);
      logic [BTN_W-1:0] res;
      for (int i = 0; i < BTN_W; i++) res[i] = |(raw & remap_rows[i]);
      return res;
    endfunction

    function flag_acc_t fold_sample(flag_acc_t a, logic [BTN_W-1:0] now,
                                    logic [BTN_W-1:0] prev, logic tick);
      logic [BTN_W-1:0] pressed, released, rep, plain_rel, cancel_rel, other;
      flag_acc_t        n;
      pressed    = ~prev & now;
      released   = prev & ~now;
      rep        = tick ? now : '0;
      // release after a trigger in this frame cancels the press
      plain_rel  = released & ~a.trig;
      // re-press after a release in this frame cancels the release
      cancel_rel = ~released & a.rel & pressed;
      other      = ~released & ~cancel_rel;
      n.hold = (a.hold & other) | (now & other) | cancel_rel;
      n.trig = (a.trig & other) | (pressed & other);
      n.rel  = (a.rel & other) | plain_rel;
      n.rpt  = (a.rpt & other) | (rep & other) | (rep & cancel_rel);
      return n;
    endfunction

    function void note_transaction(in_item_t it);
      out_item_t f;
      items_seen++;
      case (it.kind)
        KIND_SAMPLE: begin
          mapped_acc = fold_sample(mapped_acc, remap(it.raw_buttons), remap(last_raw),
                                   it.repeat_tick);
          plain_acc = fold_sample(plain_acc, it.raw_buttons, last_raw, it.repeat_tick);
          last_raw = it.raw_buttons;
          samples_seen++;
        end
        KIND_FRAME: begin
          f.mapped_hold    = mapped_acc.hold;
          f.mapped_trigger = mapped_acc.trig;
          f.mapped_release = mapped_acc.rel;
          f.mapped_repeat  = mapped_acc.trig | mapped_acc.rpt;
          f.plain_hold     = plain_acc.hold;
          f.plain_trigger  = plain_acc.trig;
          f.plain_release  = plain_acc.rel;
          f.plain_repeat   = plain_acc.trig | plain_acc.rpt;
          frames_due.push_back(f);
          mapped_acc = '0;
          plain_acc = '0;
        end
        KIND_ADD: begin
          remap_rows[it.target_button][it.source_button] = 1'b1;
          edits_seen++;
        end
        default: begin
          remap_rows[it.target_button][it.source_button] = 1'b0;
          edits_seen++;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [BTN_W-1:0] want, logic [BTN_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_frame(out_item_t got);
      out_item_t want;
      if (frames_due.size() == 0) begin
        $error("output transaction with nothing expected: %h", got);
        errors++;
        return;
      end
      want = frames_due.pop_front();
      frames_checked++;
      compare_field("mapped_hold", want.mapped_hold, got.mapped_hold);
      compare_field("mapped_trigger", want.mapped_trigger, got.mapped_trigger);
      compare_field("mapped_release", want.mapped_release, got.mapped_release);
      compare_field("mapped_repeat", want.mapped_repeat, got.mapped_repeat);
      compare_field("plain_hold", want.plain_hold, got.plain_hold);
      compare_field("plain_trigger", want.plain_trigger, got.plain_trigger);
      compare_field("plain_release", want.plain_release, got.plain_release);
      compare_field("plain_repeat", want.plain_repeat, got.plain_repeat);
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  frame_flag_board board = new();
  logic [BTN_W-1:0] sent_raw = '0;
  bit               held_off = 1'b0;

  button_edge_accumulator_remap_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("button_edge_accumulator_remap_top_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_transaction(in_data);
      if (out_valid && !out_stall) board.check_frame(out_data);
    end
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_item(kind_t k, logic [BTN_W-1:0] raw, logic tick,
                                         logic [IDX_W-1:0] tgt, logic [IDX_W-1:0] src);
    in_item_t it;
    it.kind = k;
    it.raw_buttons = raw;
    it.repeat_tick = tick;
    it.target_button = tgt;
    it.source_button = src;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    it = make_item(KIND_SAMPLE, BTN_W'($urandom), 1'($urandom),
                   IDX_W'($urandom), IDX_W'($urandom));
    r = $urandom_range(99);
    if (r < 60) begin
      r = $urandom_range(99);
      // mostly a few buttons change from the last sample, as real pads do
      if (r < 50) it.raw_buttons = sent_raw ^ (BTN_W'(1) << $urandom_range(BTN_W - 1));
      else if (r < 70) it.raw_buttons = sent_raw ^ (BTN_W'(1) << $urandom_range(BTN_W - 1))
                                                 ^ (BTN_W'(1) << $urandom_range(BTN_W - 1));
      else if (r < 80) it.raw_buttons = sent_raw;
      else if (r < 85) it.raw_buttons = '0;
      else if (r < 90) it.raw_buttons = '1;
      sent_raw = it.raw_buttons;
    end else if (r < 75) begin
      it.kind = KIND_FRAME;
    end else if (r < 88) begin
      it.kind = KIND_ADD;
    end else begin
      it.kind = KIND_REMOVE;
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_directed();
    in_item_t seq [$];
    seq.push_back(make_item(KIND_FRAME, '0, 1'b0, '0, '0));
    seq.push_back(make_item(KIND_SAMPLE, 16'hFFFF, 1'b1, '0, '0));
    seq.push_back(make_item(KIND_SAMPLE, 16'hFFFF, 1'b0, 4'hF, 4'hF));
    seq.push_back(make_item(KIND_FRAME, '0, 1'b0, '0, '0));
    seq.push_back(make_item(KIND_SAMPLE, 16'h0000, 1'b1, '0, '0));
    // re-press within the frame drops the release
    seq.push_back(make_item(KIND_SAMPLE, 16'hA5A5, 1'b1, '0, '0));
    seq.push_back(make_item(KIND_FRAME, '0, 1'b0, '0, '0));
    // releases spread over two samples in one frame, button 0 released last
    seq.push_back(make_item(KIND_SAMPLE, 16'h0001, 1'b0, '0, '0));
    seq.push_back(make_item(KIND_SAMPLE, 16'h0000, 1'b0, '0, '0));
    seq.push_back(make_item(KIND_FRAME, '0, 1'b0, '0, '0));
    seq.push_back(make_item(KIND_ADD, 16'hFFFF, 1'b1, 4'hF, 4'h0));
    seq.push_back(make_item(KIND_REMOVE, '0, 1'b0, 4'h0, 4'h0));
    seq.push_back(make_item(KIND_ADD, '0, 1'b0, 4'h0, 4'hF));
    seq.push_back(make_item(KIND_SAMPLE, 16'h0001, 1'b1, '0, '0));
    seq.push_back(make_item(KIND_SAMPLE, 16'h8000, 1'b0, '0, '0));
    seq.push_back(make_item(KIND_FRAME, '0, 1'b0, '0, '0));
    seq.push_back(make_item(KIND_REMOVE, '0, 1'b0, 4'hF, 4'h0));
    seq.push_back(make_item(KIND_ADD, '0, 1'b0, 4'h0, 4'h0));
    seq.push_back(make_item(KIND_REMOVE, '0, 1'b0, 4'h0, 4'hF));
    seq.push_back(make_item(KIND_SAMPLE, 16'h0000, 1'b1, '0, '0));
    seq.push_back(make_item(KIND_FRAME, '0, 1'b0, '0, '0));
    foreach (seq[i]) begin
      send_item(seq[i]);
      idle_gap(pick_gap());
    end
    sent_raw = '0;
  endtask

  // receiver: random stalls, open stretches, one long hold-off
  initial begin
    int stall_len;
    int open_len;
    while (rst) @(posedge clk);
    forever begin
      stall_len = pick_gap();
      open_len = ($urandom_range(9) == 0) ? 40 : $urandom_range(1, 12);
      if (!held_off && board.frames_checked >= 6) begin
        held_off = 1'b1;
        stall_len = 400;
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (open_len) @(posedge clk);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_directed();
    for (int n = 0; n < 530; n++) begin
      send_item(random_item());
      idle_gap(pick_gap());
    end
    in_valid <= 1'b0;
    // let the monitor note the last accepted transaction first
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("run covered %0d transactions: %0d samples, %0d matrix edits, %0d frames checked",
             board.items_seen, board.samples_seen, board.edits_seen, board.frames_checked);
    $display("output hold-off of 400 cycles applied: %0d", held_off);
    if (board.errors == 0) begin
      $display("button_edge_accumulator_remap_top_tb: clean");
    end else begin
      $display("button_edge_accumulator_remap_top_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/bea_pkg.sv
rtl/bea_remap.sv
rtl/bea_accum.sv
rtl/button_edge_accumulator_remap_top.sv
rtl/bea_checker.sv
sim/button_edge_accumulator_remap_top_tb.sv
